### hdl/ute_pkg.sv
// Shared types and constants for the UTF-8 terminal escape filter.
`default_nettype none
package ute_pkg;

	// One decoded item handed from the front to the back: held bytes first, then
	// the current byte, each either copied or expanded to a \xNN escape.
	typedef struct packed {
		logic [2:0][7:0] held;      // held[0] is the lead byte
		logic [7:0]      cur;
		logic [1:0]      held_n;    // number of held bytes to emit
		logic            held_esc;  // held bytes are escaped
		logic            cur_emit;  // current byte produces output
		logic            cur_esc;   // current byte is escaped
		logic            line_end;
	} job_t;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] ASCII_BSLASH = 8'h5C;
	localparam logic [7:0] ASCII_X      = 8'h78;

	// Upper-case hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/utf8_terminal_escape_filter.sv
// Top level of the UTF-8 terminal escape filter.
//
// Usage:
//   Input stream (s_*): one raw byte of a text line per item in s_tdata;
//   s_tlast marks the final byte of the line and flushes any held sequence.
//   Output stream (m_*): one terminal-safe byte per item in m_tdata.
//   m_tuser is 1 on the last output byte caused by one input item, and
//   m_tlast is 1 on the final output byte of a line.
//   Printable ASCII, LF, CR and TAB are copied; other controls, DEL, bad or
//   incomplete UTF-8 and C1 controls become \xNN escapes (four bytes each).
//   Lead bytes of multi-byte sequences are held with their continuation bytes,
//   producing nothing until the sequence completes, breaks or the line ends.
// Timing:
//   The front decodes an item in the cycle it is accepted and writes a job to
//   a two-entry queue; the back turns the head job into output bytes at one
//   byte per cycle, when m_tready allows, into an output register. First output
//   passes through a queue entry and then the output register. An item producing
//   one byte sustains one item per cycle while m_tready is high; an escape
//   gives four output bytes and a flushed sequence up to 16, so the queue can
//   fill and s_tready drops. s_tready depends only on queue occupancy, not on m_tready.
// Reset: arst_n clears the held sequence, the queue and the output valid flag.
// A stall on m_tready holds the current output item and then fills the queue.
`default_nettype none
module utf8_terminal_escape_filter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // line_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tuser,   // [0] run_last
	output logic            m_tlast    // line_last
);

	ute_pkg::job_t front_job, head_job;
	logic          push, full, pop, head_valid, accept;

	assign s_tready = ~full;
	assign accept   = s_tvalid && ~full;

	ute_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (s_tdata),
		.line_end (s_tlast),
		.job      (front_job),
		.push     (push)
	);

	ute_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (front_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	ute_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.run_last   (m_tuser),
		.line_last  (m_tlast)
	);

endmodule
`default_nettype wire

### hdl/ute_front.sv
// Front end: takes input bytes, tracks the held UTF-8 sequence, emits jobs.
`default_nettype none
module ute_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire logic          line_end,
	output ute_pkg::job_t      job,
	output logic               push
);

	logic [7:0]  held_q [3];
	logic [1:0]  count_q;
	logic [2:0]  len_q;
	logic [20:0] code_q;

	logic        f_ascii, f_safe, f_emit, f_esc;
	logic [2:0]  f_len;
	logic [20:0] f_bits;
	logic        is_cont, complete, ok;
	logic [20:0] new_code;
	logic [20:0] lowest;

	// next-state controls
	logic        do_clear, do_lead, do_store;

	// fresh-byte decode
	always_comb begin
		f_ascii = ~in_byte[7];
		f_safe  = (in_byte == 8'h0A) || (in_byte == 8'h0D) || (in_byte == 8'h09) ||
		          ((in_byte >= 8'h20) && (in_byte != 8'h7F));
		f_len   = 3'd0;
		f_bits  = '0;
		if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
			f_len  = 3'd2;
			f_bits = {16'd0, in_byte[4:0]};
		end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
			f_len  = 3'd3;
			f_bits = {17'd0, in_byte[3:0]};
		end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
			f_len  = 3'd4;
			f_bits = {18'd0, in_byte[2:0]};
		end
		f_emit = f_ascii || (f_len == 3'd0) || line_end;
		f_esc  = ~(f_ascii && f_safe);
	end

	always_comb begin
		is_cont  = (in_byte[7:6] == 2'b10);
		new_code = {code_q[14:0], in_byte[5:0]};
		complete = ({1'b0, count_q} + 3'd1) >= len_q;
		unique case (len_q)
			3'd2:    lowest = 21'h00080;
			3'd3:    lowest = 21'h00800;
			default: lowest = 21'h10000;
		endcase
		ok = (new_code >= lowest) &&
		     !((new_code >= 21'h0D800) && (new_code <= 21'h0DFFF)) &&
		     (new_code <= 21'h10FFFF) &&
		     !((new_code >= 21'h00080) && (new_code <= 21'h0009F));

		job.held     = {held_q[2], held_q[1], held_q[0]};
		job.cur      = in_byte;
		job.line_end = line_end;
		job.held_n   = 2'd0;
		job.held_esc = 1'b1;
		job.cur_emit = 1'b0;
		job.cur_esc  = 1'b1;
		do_clear     = 1'b0;
		do_lead      = 1'b0;
		do_store     = 1'b0;

		priority if (count_q == 2'd0) begin
			job.cur_emit = f_emit;
			job.cur_esc  = f_esc;
			do_lead      = ~f_emit;
		end else if (is_cont) begin
			if (complete) begin
				job.held_n   = count_q;
				job.held_esc = ~ok;
				job.cur_emit = 1'b1;
				job.cur_esc  = ~ok;
				do_clear     = 1'b1;
			end else if (line_end) begin
				job.held_n   = count_q;
				job.cur_emit = 1'b1;
				do_clear     = 1'b1;
			end else begin
				do_store = 1'b1;
			end
		end else begin
			// breaking byte: flush held bytes, then treat as fresh
			job.held_n   = count_q;
			job.cur_emit = f_emit;
			job.cur_esc  = f_esc;
			do_clear     = 1'b1;
			do_lead      = ~f_emit;
		end

		push = accept && ((job.held_n != 2'd0) || job.cur_emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
			count_q   <= '0;
			len_q     <= '0;
			code_q    <= '0;
		end else if (accept) begin
			if (do_clear) begin
				count_q <= '0;
				len_q   <= '0;
				code_q  <= '0;
			end
			if (do_lead) begin
				held_q[0] <= in_byte;
				count_q   <= 2'd1;
				len_q     <= f_len;
				code_q    <= f_bits;
			end
			if (do_store) begin
				held_q[count_q] <= in_byte;
				count_q         <= count_q + 2'd1;
				code_q          <= new_code;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_held_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd0) |-> (len_q >= 3'd2 && len_q <= 3'd4 && {1'b0, count_q} < len_q))
		else $error("held sequence shape inconsistent");
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> (code_q == 21'd0 && len_q == 3'd0))
		else $error("idle state carries stale sequence data");
`endif

endmodule
`default_nettype wire

### hdl/ute_queue.sv
// Two-entry job queue between the front and the back.
`default_nettype none
module ute_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ute_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output ute_pkg::job_t      head_job
);

	localparam int unsigned PW = $clog2(ute_pkg::QUEUE_DEPTH);

	ute_pkg::job_t         mem_q [ute_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [PW:0]           count_q;
	logic                  do_push, do_pop;

	assign full       = (count_q == (PW+1)'(ute_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(ute_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(ute_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(ute_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");
`endif

endmodule
`default_nettype wire

### hdl/ute_back.sv
// Back end: expands queued jobs into output bytes, one per cycle unless the output stalls.
`default_nettype none
module ute_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire ute_pkg::job_t head_job,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               line_last
);

	logic [1:0] idx_q;      // slot within the job
	logic [1:0] sub_q;      // byte within an escape
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_q, line_q;

	logic       on_cur, esc, slot_done, last_slot, job_done, step;
	logic [7:0] src, nxt_byte;

	always_comb begin
		on_cur    = (idx_q == head_job.held_n);
		src       = on_cur ? head_job.cur : head_job.held[idx_q];
		esc       = on_cur ? head_job.cur_esc : head_job.held_esc;
		slot_done = ~esc || (sub_q == 2'd3);
		last_slot = head_job.cur_emit ? on_cur : (idx_q == (head_job.held_n - 2'd1));
		job_done  = last_slot && slot_done;
		step      = head_valid && (!valid_q || out_ready);
		pop       = step && job_done;
		if (!esc) begin
			nxt_byte = src;
		end else begin
			unique case (sub_q)
				2'd0: nxt_byte = ute_pkg::ASCII_BSLASH;
				2'd1: nxt_byte = ute_pkg::ASCII_X;
				2'd2: nxt_byte = ute_pkg::hex_char(src[7:4]);
				2'd3: nxt_byte = ute_pkg::hex_char(src[3:0]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= nxt_byte;
			run_q  <= job_done;
			line_q <= job_done && head_job.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			sub_q   <= '0;
		end else begin
			if (step) begin
				valid_q <= 1'b1;
				if (job_done) begin
					idx_q <= '0;
					sub_q <= '0;
				end else if (slot_done) begin
					idx_q <= idx_q + 2'd1;
					sub_q <= '0;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_last  = run_q;
	assign line_last = line_q;

`ifndef NO_ASSERTIONS
	a_sub_only_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && sub_q != 2'd0) |-> esc)
		else $error("escape step counter active on a copied byte");
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_job.held_n))
		else $error("slot index past end of job");
`endif

endmodule
`default_nettype wire
